[rtl/core/apm_pkg.sv]
// Shared types, constants and helpers of the avoidance progress monitor.
`timescale 1ns / 1ps

package apm_pkg;

    // Widths
    localparam int COUNT_BITS = 32;
    localparam int POS_BITS   = 24;
    localparam int DIST_BITS  = 24;
    localparam int ANG_BITS   = 16;
    localparam int CFG_BITS   = 16;
    localparam int FIELD32    = 32;

    // Input word packing, lowest field first
    localparam int IN_POSX_LO  = 0;
    localparam int IN_POSZ_LO  = IN_POSX_LO + POS_BITS;
    localparam int IN_HEAD_LO  = IN_POSZ_LO + POS_BITS;
    localparam int IN_TGT_LO   = IN_HEAD_LO + ANG_BITS;
    localparam int IN_LEFT_LO  = IN_TGT_LO + DIST_BITS;
    localparam int IN_HOLD_LO  = IN_LEFT_LO + 1;
    localparam int IN_OBST_LO  = IN_HOLD_LO + 16;
    localparam int IN_DR_LO    = IN_OBST_LO + 1;
    localparam int IN_BITS     = IN_DR_LO + DIST_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Result word: 3 flags, hold, five counters, turn total, best distance
    localparam int OUT_BITS    = 3 + 16 + 6 * FIELD32 + DIST_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int ADDR_BITS = 5;
    localparam int APB_BITS  = 32;

    localparam logic [2:0] REG_STUCK_POSE_EPS  = 3'd0;
    localparam logic [2:0] REG_STUCK_PROG_EPS  = 3'd1;
    localparam logic [2:0] REG_BEST_PROG_EPS   = 3'd2;
    localparam logic [2:0] REG_MIN_CONTOUR     = 3'd3;
    localparam logic [2:0] REG_DETOUR_REACHED  = 3'd4;

    localparam logic [CFG_BITS-1:0] RST_STUCK_POSE_EPS = 16'd20;
    localparam logic [CFG_BITS-1:0] RST_STUCK_PROG_EPS = 16'd10;
    localparam logic [CFG_BITS-1:0] RST_BEST_PROG_EPS  = 16'd50;
    localparam logic [CFG_BITS-1:0] RST_MIN_CONTOUR    = 16'd20;
    localparam logic [CFG_BITS-1:0] RST_DETOUR_REACHED = 16'd150;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_BEGIN  = 2'd1,
        CMD_ARM    = 2'd2,
        CMD_UPDATE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] stuck_pose_eps;
        logic [CFG_BITS-1:0] stuck_progress_eps;
        logic [CFG_BITS-1:0] best_progress_eps;
        logic [CFG_BITS-1:0] contour_grace;
        logic [CFG_BITS-1:0] detour_reached_mm;
    } cfg_t;

    typedef struct packed {
        cmd_t                  command;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_z;
        logic [ANG_BITS-1:0]   heading;
        logic [DIST_BITS-1:0]  goal_dist;
        logic                  turn_left;
        logic [15:0]           hold_count;
        logic                  obstacle_present;
        logic [DIST_BITS-1:0]  detour_range;
    } item_t;

    typedef struct packed {
        logic                  active;
        logic                  side_left;
        logic                  detour;
        logic [15:0]           hold;
        logic [POS_BITS-1:0]   last_x;
        logic [POS_BITS-1:0]   last_z;
        logic [DIST_BITS-1:0]  last_target;
        logic [DIST_BITS-1:0]  best_target;
        logic [ANG_BITS-1:0]   last_heading;
        logic [FIELD32-1:0]    turn_accum;
        logic [COUNT_BITS-1:0] contour;
        logic [COUNT_BITS-1:0] stuck;
        logic [COUNT_BITS-1:0] stall;
        logic [COUNT_BITS-1:0] clear;
        logic [COUNT_BITS-1:0] free;
    } state_t;

    localparam state_t STATE_RESET = '{
        active: 1'b0, side_left: 1'b0, detour: 1'b0, hold: '0,
        last_x: '0, last_z: '0, last_target: '0, best_target: '0,
        last_heading: '0, turn_accum: '0,
        contour: '0, stuck: '0, stall: '0, clear: '0, free: '0
    };

    // Saturating increment of a step counter
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

[rtl/core/apm_cfg_regs.sv]
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module apm_cfg_regs
    import apm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [APB_BITS-1:0]  pwdata,
    output logic [APB_BITS-1:0]  prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    // Register writes; addresses past the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stuck_pose_eps     <= RST_STUCK_POSE_EPS;
            cfg_reg.stuck_progress_eps <= RST_STUCK_PROG_EPS;
            cfg_reg.best_progress_eps  <= RST_BEST_PROG_EPS;
            cfg_reg.contour_grace      <= RST_MIN_CONTOUR;
            cfg_reg.detour_reached_mm  <= RST_DETOUR_REACHED;
        end else if (wr_en) begin
            unique case (idx)
                REG_STUCK_POSE_EPS: cfg_reg.stuck_pose_eps     <= pwdata[CFG_BITS-1:0];
                REG_STUCK_PROG_EPS: cfg_reg.stuck_progress_eps <= pwdata[CFG_BITS-1:0];
                REG_BEST_PROG_EPS:  cfg_reg.best_progress_eps  <= pwdata[CFG_BITS-1:0];
                REG_MIN_CONTOUR:    cfg_reg.contour_grace      <= pwdata[CFG_BITS-1:0];
                REG_DETOUR_REACHED: cfg_reg.detour_reached_mm  <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_STUCK_POSE_EPS: prdata = {{(APB_BITS-CFG_BITS){1'b0}}, cfg_reg.stuck_pose_eps};
            REG_STUCK_PROG_EPS: prdata = {{(APB_BITS-CFG_BITS){1'b0}}, cfg_reg.stuck_progress_eps};
            REG_BEST_PROG_EPS:  prdata = {{(APB_BITS-CFG_BITS){1'b0}}, cfg_reg.best_progress_eps};
            REG_MIN_CONTOUR:    prdata = {{(APB_BITS-CFG_BITS){1'b0}}, cfg_reg.contour_grace};
            REG_DETOUR_REACHED: prdata = {{(APB_BITS-CFG_BITS){1'b0}}, cfg_reg.detour_reached_mm};
            default:            prdata = '0;
        endcase
    end

endmodule

[rtl/core/apm_step.sv]
// Next-state logic for one command word: clear, begin, arm detour or update.
`timescale 1ns / 1ps

module apm_step
    import apm_pkg::*;
(
    input  item_t  item,
    input  state_t cur,
    input  cfg_t   cfg,
    output state_t nxt
);

    localparam int DW = POS_BITS + 1;

    logic signed [DW-1:0]      dx, dz;
    logic [DW-1:0]             ax, az;
    logic [DW-1:0]             eps_w;
    logic [31:0]               sq_x, sq_z, eps_sq;
    logic [32:0]               sq_sum;
    logic                      unmoved, no_progress, stuck, new_best, reached;
    logic [ANG_BITS-1:0]       d_head;
    logic [ANG_BITS:0]         mag;
    logic [FIELD32:0]          acc_sum;
    logic [DIST_BITS:0]        tgt_plus_prog, tgt_plus_best;
    logic [COUNT_BITS-1:0]     contour_n, clear_1;
    logic [FIELD32-1:0]        contour_w, min_w;

    // Displacement since last sample, one bit wider than a position
    always_comb begin
        dx = $signed({item.pos_x[POS_BITS-1], item.pos_x})
           - $signed({cur.last_x[POS_BITS-1], cur.last_x});
        dz = $signed({item.pos_z[POS_BITS-1], item.pos_z})
           - $signed({cur.last_z[POS_BITS-1], cur.last_z});
        ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
        az = dz[DW-1] ? DW'(-dz) : DW'(dz);
    end

    // Stuck test: squares only matter while both axes sit below eps
    always_comb begin
        eps_w   = {{(DW-CFG_BITS){1'b0}}, cfg.stuck_pose_eps};
        sq_x    = {16'd0, ax[15:0]} * {16'd0, ax[15:0]};
        sq_z    = {16'd0, az[15:0]} * {16'd0, az[15:0]};
        eps_sq  = {16'd0, cfg.stuck_pose_eps} * {16'd0, cfg.stuck_pose_eps};
        sq_sum  = {1'b0, sq_x} + {1'b0, sq_z};
        unmoved = (ax < eps_w) && (az < eps_w) && (sq_sum < {1'b0, eps_sq});
        // last - tgt < eps  <=>  last < tgt + eps
        tgt_plus_prog = {1'b0, item.goal_dist}
                      + {{(DIST_BITS+1-CFG_BITS){1'b0}}, cfg.stuck_progress_eps};
        no_progress   = {1'b0, cur.last_target} < tgt_plus_prog;
        stuck         = unmoved && no_progress;
    end

    // Wrapped heading magnitude and saturating accumulation
    always_comb begin
        d_head  = item.heading - cur.last_heading;
        mag     = d_head[ANG_BITS-1] ? (17'h10000 - {1'b0, d_head}) : {1'b0, d_head};
        acc_sum = {1'b0, cur.turn_accum} + {{(FIELD32-ANG_BITS){1'b0}}, mag};
    end

    // Best distance and detour tests
    always_comb begin
        tgt_plus_best = {1'b0, item.goal_dist}
                      + {{(DIST_BITS+1-CFG_BITS){1'b0}}, cfg.best_progress_eps};
        new_best  = tgt_plus_best < {1'b0, cur.best_target};
        reached   = cur.detour && (item.detour_range
                  < {{(DIST_BITS-CFG_BITS){1'b0}}, cfg.detour_reached_mm});
        contour_n = sat_inc(cur.contour);
        contour_w = FIELD32'(contour_n);
        min_w     = {{(FIELD32-CFG_BITS){1'b0}}, cfg.contour_grace};
        clear_1   = item.obstacle_present ? '0 : sat_inc(cur.clear);
    end

    // Command decode
    always_comb begin
        nxt = cur;
        unique case (item.command)
            CMD_CLEAR: begin
                nxt        = STATE_RESET;
                nxt.last_x = item.pos_x;
                nxt.last_z = item.pos_z;
            end
            CMD_BEGIN: begin
                nxt.active       = 1'b1;
                nxt.side_left    = !item.turn_left;
                nxt.hold         = item.hold_count;
                nxt.last_x       = item.pos_x;
                nxt.last_z       = item.pos_z;
                nxt.last_target  = item.goal_dist;
                nxt.best_target  = item.goal_dist;
                nxt.last_heading = item.heading;
                nxt.turn_accum   = '0;
                nxt.contour      = '0;
                nxt.stuck        = '0;
                nxt.stall        = '0;
                nxt.clear        = '0;
                nxt.free         = '0;
            end
            CMD_ARM: begin
                nxt.detour = 1'b1;
            end
            CMD_UPDATE: begin
                nxt.contour      = contour_n;
                nxt.hold         = (cur.hold != '0) ? cur.hold - 1'b1 : cur.hold;
                nxt.turn_accum   = acc_sum[FIELD32] ? '1 : acc_sum[FIELD32-1:0];
                nxt.last_heading = item.heading;
                nxt.stuck        = stuck ? sat_inc(cur.stuck) : '0;
                nxt.last_x       = item.pos_x;
                nxt.last_z       = item.pos_z;
                nxt.last_target  = item.goal_dist;
                if (new_best) begin
                    nxt.best_target = item.goal_dist;
                    nxt.stall       = '0;
                end else if (contour_w > min_w) begin
                    nxt.stall = sat_inc(cur.stall);
                end
                nxt.free   = item.obstacle_present ? '0 : sat_inc(cur.free);
                nxt.clear  = reached ? sat_inc(clear_1) : clear_1;
                if (reached) begin
                    nxt.detour = 1'b0;
                end
            end
            default: nxt = cur;
        endcase
    end

endmodule

[rtl/core/avoidance_progress_monitor.sv]
// Top level of the avoidance progress monitor: input register, episode state, handshakes.
//
//   channel  | direction | handshake               | contents
//   ---------+-----------+-------------------------+-------------------------------
//   s_       | in        | s_tvalid / s_tready     | command in tuser, sample in tdata
//   m_       | out       | m_tvalid / m_tready     | episode state after each command
//   APB      | in/out    | psel, penable, pready   | five 16-bit thresholds at 4*i
//
// One word per cycle sustained while m_tready stays high; a word passes the input
// register, then one pass of the step logic into the state register.
// The state register is the result register, so it only advances when the
// previous result has gone or is leaving. Reset (synchronous, active low)
// clears the state, empties both stages and restores the threshold defaults.
// A stall on m_ holds one word in the input register before s_tready drops.
`timescale 1ns / 1ps

module avoidance_progress_monitor
    import apm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata, from bit 0: pos_x, pos_z, heading, goal distance, turn_left,
    // hold_count, obstacle_present, detour_range, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tuser: command
    input  logic [1:0]             s_tuser,
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata, from bit 0: episode_active, obstacle_on_left, detour_armed,
    // hold_left, contour_count, stuck_count, stall_count, clear_count,
    // free_count, turn_total, best_distance, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [APB_BITS-1:0]    pwdata,
    output logic [APB_BITS-1:0]    prdata,
    output logic                   pready
);

    cfg_t   cfg;
    item_t  in_item_reg;
    logic   in_valid_reg;
    logic   out_valid_reg;
    state_t state_reg;
    state_t state_next;
    logic   fire;

    apm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apm_step u_step (
        .item (in_item_reg),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next)
    );

    // Handshake: step fires when a word waits and the result slot frees up
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.command          <= cmd_t'(s_tuser);
            in_item_reg.pos_x            <= s_tdata[IN_POSX_LO +: POS_BITS];
            in_item_reg.pos_z            <= s_tdata[IN_POSZ_LO +: POS_BITS];
            in_item_reg.heading          <= s_tdata[IN_HEAD_LO +: ANG_BITS];
            in_item_reg.goal_dist        <= s_tdata[IN_TGT_LO +: DIST_BITS];
            in_item_reg.turn_left        <= s_tdata[IN_LEFT_LO];
            in_item_reg.hold_count       <= s_tdata[IN_HOLD_LO +: 16];
            in_item_reg.obstacle_present <= s_tdata[IN_OBST_LO];
            in_item_reg.detour_range     <= s_tdata[IN_DR_LO +: DIST_BITS];
        end
    end

    // Episode state, doubling as the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= state_next;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word packing
    assign m_tdata = {
        {(OUT_TDATA_W-OUT_BITS){1'b0}},
        state_reg.best_target,
        state_reg.turn_accum,
        FIELD32'(state_reg.free),
        FIELD32'(state_reg.clear),
        FIELD32'(state_reg.stall),
        FIELD32'(state_reg.stuck),
        FIELD32'(state_reg.contour),
        state_reg.hold,
        state_reg.detour,
        state_reg.side_left,
        state_reg.active
    };

endmodule
